>>> rtl/sitoa_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII block.
// No dependencies; used by sitoa_back and signed_int_to_decimal_ascii.
`default_nettype none

package sitoa_pkg;

  // Width of one output character code
  localparam int unsigned CHAR_W = 6;

  // ASCII codes, truncated to the character width
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_SIGN,
    BK_DIGIT
  } back_state_e;

endpackage

`default_nettype wire

>>> rtl/sitoa_front.sv
// Front end: splits an incoming signed value into sign and unsigned magnitude.
// No package dependencies; feeds sitoa_fifo.
`default_nettype none

module sitoa_front #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                               neg_o,
  output logic             [VALUE_WIDTH-1:0] mag_o
);

  // Take the magnitude as an unsigned word so the most negative value is exact
  always_comb begin
    neg_o = value_i[VALUE_WIDTH-1];
    if (neg_o) begin
      mag_o = (~value_i) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
    end else begin
      mag_o = value_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sitoa_fifo.sv
// Two-entry queue that decouples the front end from the conversion back end.
// No package dependencies.
`default_nettype none

module sitoa_fifo #(
  parameter int unsigned WIDTH = 33
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             enq_i,
  input  wire logic [WIDTH-1:0] enq_data_i,
  output logic                  full_o,
  input  wire logic             deq_i,
  output logic      [WIDTH-1:0] deq_data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_enq, do_deq;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign deq_data_o = entry_q[rd_ptr_q];
  assign do_enq     = enq_i && !full_o;
  assign do_deq     = deq_i && !empty_o;

  // Advance pointers and track occupancy
  always_comb begin
    wr_ptr_d = do_enq ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_deq ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_enq && !do_deq) begin
      count_d = count_q + 2'd1;
    end else if (!do_enq && do_deq) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      entry_q[wr_ptr_q] <= enq_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sitoa_back.sv
// Back end: bit-serial double-dabble conversion and character emission
// through a one-word output register. Depends on sitoa_pkg.
`default_nettype none

module sitoa_back #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // queue side
  input  wire logic                              q_empty_i,
  input  wire logic                              q_neg_i,
  input  wire logic [VALUE_WIDTH-1:0]            q_mag_i,
  output logic                                   deq_o,
  // result side
  output logic                                   out_valid_o,
  output logic      [sitoa_pkg::CHAR_W-1:0]      character_o,
  output logic                                   last_o,
  input  wire logic                              pop_i
);

  // Decimal digits needed for any magnitude up to 2^(VALUE_WIDTH-1)
  localparam int unsigned NDIG  = (VALUE_WIDTH * 302) / 1000 + 1;
  localparam int unsigned IDX_W = $clog2(NDIG);
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

  sitoa_pkg::back_state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0]       bin_q;
  logic                         neg_q;
  logic [3:0]                   digit_q [NDIG];
  logic [3:0]                   digit_shift [NDIG];
  logic [3:0]                   digit_adj [NDIG];
  logic [CNT_W-1:0]             cnt_q;
  logic [IDX_W-1:0]             idx_q;
  logic                         started_q;

  logic                         out_valid_q;
  logic [sitoa_pkg::CHAR_W-1:0] char_q;
  logic                         last_q;

  logic                         out_free;
  logic [3:0]                   cur_digit;
  logic                         show_digit;
  logic                         out_load;
  logic [sitoa_pkg::CHAR_W-1:0] out_char;
  logic                         out_last;

  assign out_free    = !out_valid_q || pop_i;
  assign cur_digit   = digit_q[idx_q];
  assign show_digit  = started_q || (cur_digit != 4'd0) || (idx_q == '0);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // Add three to every digit of five or more, then shift in the next binary bit
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      digit_adj[i] = (digit_q[i] >= 4'd5) ? (digit_q[i] + 4'd3) : digit_q[i];
    end
    for (int i = 0; i < NDIG; i++) begin
      if (i == 0) begin
        digit_shift[i] = {digit_adj[i][2:0], bin_q[VALUE_WIDTH-1]};
      end else begin
        digit_shift[i] = {digit_adj[i][2:0], digit_adj[i-1][3]};
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sitoa_pkg::BK_IDLE: begin
        if (!q_empty_i) state_d = sitoa_pkg::BK_CONV;
      end
      sitoa_pkg::BK_CONV: begin
        if (cnt_q == '0) state_d = neg_q ? sitoa_pkg::BK_SIGN : sitoa_pkg::BK_DIGIT;
      end
      sitoa_pkg::BK_SIGN: begin
        if (out_free) state_d = sitoa_pkg::BK_DIGIT;
      end
      sitoa_pkg::BK_DIGIT: begin
        if (show_digit && out_free && (idx_q == '0)) state_d = sitoa_pkg::BK_IDLE;
      end
      default: state_d = sitoa_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    deq_o    = 1'b0;
    out_load = 1'b0;
    out_char = sitoa_pkg::ASCII_ZERO;
    out_last = 1'b0;
    case (state_q)
      sitoa_pkg::BK_IDLE: begin
        deq_o = !q_empty_i;
      end
      sitoa_pkg::BK_SIGN: begin
        out_load = out_free;
        out_char = sitoa_pkg::ASCII_MINUS;
      end
      sitoa_pkg::BK_DIGIT: begin
        out_load = show_digit && out_free;
        out_char = sitoa_pkg::ASCII_ZERO + {2'b00, cur_digit};
        out_last = (idx_q == '0);
      end
      default: begin
        deq_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sitoa_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load, convert and scan the digit registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      sitoa_pkg::BK_IDLE: begin
        bin_q <= q_mag_i;
        neg_q <= q_neg_i;
        cnt_q <= CNT_W'(VALUE_WIDTH - 1);
        for (int i = 0; i < NDIG; i++) begin
          digit_q[i] <= 4'd0;
        end
      end
      sitoa_pkg::BK_CONV: begin
        bin_q     <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
        cnt_q     <= cnt_q - {{(CNT_W-1){1'b0}}, 1'b1};
        idx_q     <= IDX_W'(NDIG - 1);
        started_q <= 1'b0;
        for (int i = 0; i < NDIG; i++) begin
          digit_q[i] <= digit_shift[i];
        end
      end
      sitoa_pkg::BK_DIGIT: begin
        if (!show_digit) begin
          idx_q <= idx_q - {{(IDX_W-1){1'b0}}, 1'b1};
        end else if (out_free) begin
          started_q <= 1'b1;
          if (idx_q != '0) idx_q <= idx_q - {{(IDX_W-1){1'b0}}, 1'b1};
        end
      end
      default: begin
        neg_q <= neg_q;
      end
    endcase
  end

  // Hold the output word
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      char_q <= out_char;
      last_q <= out_last;
    end
  end

  // A waiting word is never overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q && $stable(char_q) && $stable(last_q))
    else $error("output word changed while waiting");

  // The sign never ends a number
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (out_char == sitoa_pkg::ASCII_MINUS) |-> !out_last)
    else $error("minus sign flagged as last");

  // Conversion runs until the bit counter runs out
  a_conv_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sitoa_pkg::BK_CONV) && (cnt_q != '0) |=> (state_q == sitoa_pkg::BK_CONV))
    else $error("conversion ended early");

  // Dequeue only from a non-empty queue and only while idle
  a_deq_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_o |-> !q_empty_i && (state_q == sitoa_pkg::BK_IDLE))
    else $error("dequeue from empty queue or while busy");

endmodule

`default_nettype wire

>>> rtl/signed_int_to_decimal_ascii.sv
// Throughput is set by the bit-serial double-dabble loop and the one-digit per cycle
// scan of the decimal register, which holds while the output word waits to be popped;
// the two-entry queue accepts new numbers while one is being converted.
// Reset: asynchronous active low; clears the queue, sequencer and output valid flag.
// Top level: front classifier, two-entry queue, conversion back end; uses sitoa_pkg.
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic signed [VALUE_WIDTH-1:0]        value_i,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic             [sitoa_pkg::CHAR_W-1:0]  character_o,
  output logic                                      last_o
);

  logic                   front_neg;
  logic [VALUE_WIDTH-1:0] front_mag;
  logic [VALUE_WIDTH:0]   q_data;
  logic                   q_empty;
  logic                   deq;
  logic                   out_valid;

  // Classify the incoming word
  sitoa_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .value_i (value_i),
    .neg_o   (front_neg),
    .mag_o   (front_mag)
  );

  // Queue sign and magnitude
  sitoa_fifo #(.WIDTH(VALUE_WIDTH + 1)) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enq_i      (push),
    .enq_data_i ({front_neg, front_mag}),
    .full_o     (full),
    .deq_i      (deq),
    .deq_data_o (q_data),
    .empty_o    (q_empty)
  );

  // Convert and emit characters
  sitoa_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_neg_i     (q_data[VALUE_WIDTH]),
    .q_mag_i     (q_data[VALUE_WIDTH-1:0]),
    .deq_o       (deq),
    .out_valid_o (out_valid),
    .character_o (character_o),
    .last_o      (last_o),
    .pop_i       (pop)
  );

  assign empty = !out_valid;

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Testbench for signed_int_to_decimal_ascii: pushes signed 32-bit values and checks
// every ASCII character word and its last flag against a local decimal speller.
// Depends on sitoa_pkg and the signed_int_to_decimal_ascii RTL only.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned VW         = 32;
  localparam int          RAND_WORDS = 500;
  localparam int          HOLD_AFTER = 200;
  localparam int          HOLD_LEN   = 300;
  localparam int          DRAIN_WAIT = 60;
  localparam int          MAX_SHOWN  = 20;

  typedef struct packed {
    logic [sitoa_pkg::CHAR_W-1:0] code;
    logic                         last;
  } ascii_word_t;

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          push         = 1'b0;
  logic signed [VW-1:0]          value_i      = '0;
  logic                          pop          = 1'b0;
  logic                          full;
  logic                          empty;
  logic [sitoa_pkg::CHAR_W-1:0]  character_o;
  logic                          last_o;

  logic                          hold_results = 1'b0;

  logic signed [VW-1:0] pending_values [$];
  ascii_word_t          expected_chars [$];

  int numbers_in;
  int negatives_in;
  int chars_out;
  int numbers_out;
  int full_stalls;
  int errors;
  int send_gap;
  int recv_gap;
  int next_gap;

  signed_int_to_decimal_ascii #(
    .VALUE_WIDTH(VW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .value_i    (value_i),
    .empty      (empty),
    .pop        (pop),
    .character_o(character_o),
    .last_o     (last_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Print one mismatch line (first few only) and count it
  task automatic report_mismatch(input string what);
    if (errors < MAX_SHOWN) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
    errors++;
  endtask

  // Wait draw per word: some stretches run with no idling at all
  function automatic int draw_gap(input int seq);
    return (seq % 97 < 25) ? 0 : int'($urandom_range(0, 9));
  endfunction

  // Spell a value in decimal, sign first, and queue the expected words
  function automatic void spell_decimal(input logic signed [VW-1:0] v);
    logic [VW-1:0] mag;
    logic [3:0]    digits [$];
    ascii_word_t   w;
    mag = v;
    if (v[VW-1]) begin
      mag = '0 - mag;
      w.code = sitoa_pkg::ASCII_MINUS;
      w.last = 1'b0;
      expected_chars.push_back(w);
    end
    do begin
      digits.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != '0);
    foreach (digits[k]) begin
      w.code = sitoa_pkg::ASCII_ZERO + sitoa_pkg::CHAR_W'(digits[k]);
      w.last = (k == digits.size() - 1);
      expected_chars.push_back(w);
    end
  endfunction

  // Driver: hold a word under full, otherwise predict on accept and load the next
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push     <= 1'b0;
      value_i  <= '0;
      send_gap <= 0;
    end else if (push && full) begin
      full_stalls++;
    end else begin
      if (push) begin
        spell_decimal(value_i);
        numbers_in++;
        if (value_i[VW-1]) negatives_in++;
        next_gap = draw_gap(numbers_in);
      end else begin
        next_gap = send_gap;
      end
      if (next_gap > 0) begin
        push     <= 1'b0;
        send_gap <= next_gap - 1;
      end else if (pending_values.size() > 0) begin
        push     <= 1'b1;
        value_i  <= pending_values.pop_front();
        send_gap <= 0;
      end else begin
        push     <= 1'b0;
        send_gap <= 0;
      end
    end
  end

  // Monitor: compare each accepted word with the oldest expectation, then pace pop
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    ascii_word_t want;
    int          gap;
    if (!rst_ni) begin
      pop      <= 1'b0;
      recv_gap <= 0;
    end else begin
      gap = recv_gap;
      if (pop && !empty) begin
        chars_out++;
        if (last_o) numbers_out++;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected word char=%0d last=%0b",
                                    character_o, last_o));
        end else begin
          want = expected_chars.pop_front();
          if (character_o !== want.code) begin
            report_mismatch($sformatf("char %0d, expected %0d", character_o, want.code));
          end
          if (last_o !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", last_o, want.last));
          end
        end
        gap = draw_gap(chars_out);
      end
      if (hold_results) begin
        pop      <= 1'b0;
        recv_gap <= gap;
      end else if (gap > 0) begin
        pop      <= 1'b0;
        recv_gap <= gap - 1;
      end else begin
        pop      <= 1'b1;
        recv_gap <= 0;
      end
    end
  end

  // Long receiver stall partway through so the block backs up and raises full
  initial begin
    while (numbers_in < HOLD_AFTER) @(posedge clk_i);
    hold_results <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    hold_results <= 1'b0;
  end

  // Stimulus, drain and verdict
  initial begin
    logic signed [VW-1:0] v;
    logic        [VW-1:0] pow10;
    int                   nbits;
    int                   k;
    int                   total_words;

    // Directed: extremes, zero, sign handling, digit-count edges
    pending_values.push_back(0);
    pending_values.push_back(1);
    pending_values.push_back(-1);
    pending_values.push_back(9);
    pending_values.push_back(-9);
    pending_values.push_back(10);
    pending_values.push_back(-10);
    pending_values.push_back(99);
    pending_values.push_back(100);
    pending_values.push_back(32'sh7fffffff);
    pending_values.push_back(32'sh80000000);
    pending_values.push_back(32'sh80000001);
    pending_values.push_back(1000000000);
    pending_values.push_back(999999999);
    pending_values.push_back(-1000000000);
    pending_values.push_back(32'sh55555555);
    pending_values.push_back(32'shaaaaaaaa);
    pending_values.push_back(1234567890);
    pending_values.push_back(-123456789);
    pending_values.push_back(7);

    // Random: full words, short magnitudes of either sign, powers of ten or one below
    for (int i = 0; i < RAND_WORDS; i++) begin
      case ($urandom_range(0, 2))
        0: begin
          v = $urandom;
        end
        1: begin
          nbits = $urandom_range(1, VW - 1);
          v = $urandom & ((32'd1 << nbits) - 1);
          if ($urandom_range(0, 1)) v = -v;
        end
        default: begin
          k = $urandom_range(0, 9);
          pow10 = 1;
          repeat (k) pow10 = pow10 * 10;
          v = pow10 - $urandom_range(0, 1);
          if ($urandom_range(0, 1)) v = -v;
        end
      endcase
      pending_values.push_back(v);
    end
    total_words = pending_values.size();

    // Hold reset, then release it
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all words accepted, all characters back, then a quiet tail
    while (numbers_in < total_words) @(posedge clk_i);
    while (expected_chars.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d numbers (%0d negative) as %0d characters, %0d last flags",
             numbers_in, negatives_in, chars_out, numbers_out);
    $display("input held off by full for %0d cycles, %0d mismatches", full_stalls, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> signed_int_to_decimal_ascii.f
rtl/sitoa_pkg.sv
rtl/sitoa_front.sv
rtl/sitoa_fifo.sv
rtl/sitoa_back.sv
rtl/signed_int_to_decimal_ascii.sv
test/tb_top.sv
